// File: rtl/euler_point_mass_integrator_assert.svh
// -----------------------------------------------------------------------------
// Assertion macros for the point-mass integrator
// Implication checks clocked on i_clk and disabled while i_rst_n is low.
// -----------------------------------------------------------------------------
`ifndef EULER_POINT_MASS_INTEGRATOR_ASSERT_SVH
`define EULER_POINT_MASS_INTEGRATOR_ASSERT_SVH

// Same-cycle implication.
`define EPMI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define EPMI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/epmi_pkg.sv
// -----------------------------------------------------------------------------
// epmi_pkg
// Types, constants, helpers and the microcode store of the point-mass integrator.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package epmi_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int MASS_W    = 31;
    localparam int DUR_W     = 24;
    localparam int OPC_W     = 2;
    localparam int SUBSTEP   = 655;
    localparam int H_W       = $clog2(SUBSTEP + 1);
    localparam int PROD_W    = H_W + DATA_W;
    localparam int DIV_W     = DATA_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int ACC_W     = DATA_W + 2;
    localparam int PC_W      = 5;

    localparam logic [MASS_W-1:0] MASS_RESET = MASS_W'(65536);
    localparam logic [DATA_W-1:0] S32_MAX    = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] S32_MIN    = {1'b1, {(DATA_W-1){1'b0}}};

    // Item opcodes.
    localparam logic [OPC_W-1:0] OPC_ADVANCE = 2'd0;
    localparam logic [OPC_W-1:0] OPC_LD_POS  = 2'd1;
    localparam logic [OPC_W-1:0] OPC_LD_VEL  = 2'd2;

    typedef logic [PC_W-1:0] t_pc;

    // Microcode addresses.
    localparam t_pc PC_FETCH      = 5'd0;
    localparam t_pc PC_DISP_LDP   = 5'd1;
    localparam t_pc PC_DISP_LDV   = 5'd2;
    localparam t_pc PC_DISP_NONE  = 5'd3;
    localparam t_pc PC_DISP_QUIET = 5'd4;
    localparam t_pc PC_DIV_START  = 5'd5;
    localparam t_pc PC_DIV_STEP   = 5'd6;
    localparam t_pc PC_DIV_END    = 5'd7;
    localparam t_pc PC_ADD_IMP    = 5'd8;
    localparam t_pc PC_H_PICK     = 5'd9;
    localparam t_pc PC_MUL_V      = 5'd10;
    localparam t_pc PC_ADD_P      = 5'd11;
    localparam t_pc PC_MUL_A      = 5'd12;
    localparam t_pc PC_ADD_V      = 5'd13;
    localparam t_pc PC_ADV_DONE   = 5'd14;
    localparam t_pc PC_LOAD_P     = 5'd15;
    localparam t_pc PC_LOAD_V     = 5'd16;
    localparam t_pc PC_EMIT       = 5'd17;
    localparam t_pc PC_RETURN     = 5'd18;

    typedef enum logic [3:0] {
        U_NOP,
        U_LATCH,
        U_DIV_START,
        U_DIV_STEP,
        U_DIV_END,
        U_ADD_IMP,
        U_H_PICK,
        U_MUL_V,
        U_ADD_P,
        U_MUL_A,
        U_ADD_V,
        U_LOAD_P,
        U_LOAD_V,
        U_EMIT
    } t_uop;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_OP_LDP,
        C_OP_LDV,
        C_OP_NONE,
        C_QUIET,
        C_DIV_BUSY,
        C_DUR_NZ,
        C_LEFT_NZ,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_pc   tgt;
    } t_uword;

    typedef struct packed {
        logic        [OPC_W-1:0]  opcode;
        logic        [DUR_W-1:0]  step_size;
        logic signed [DATA_W-1:0] force_req;
        logic signed [DATA_W-1:0] impulse;
        logic signed [DATA_W-1:0] load_value;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] position_out;
        logic signed [DATA_W-1:0] velocity_out;
        logic                     saturated;
    } t_out;

    function automatic t_uword f_uw(t_uop op, t_cond cond, t_pc tgt);
        t_uword w;
        w.op   = op;
        w.cond = cond;
        w.tgt  = tgt;
        return w;
    endfunction

    // The control program. A word jumps to its target when its condition
    // holds and otherwise falls through to the next address.
    function automatic t_uword f_urom(t_pc pc);
        t_uword w;
        unique case (pc)
            PC_FETCH:      w = f_uw(U_LATCH,     C_NO_IN,    PC_FETCH);
            PC_DISP_LDP:   w = f_uw(U_NOP,       C_OP_LDP,   PC_LOAD_P);
            PC_DISP_LDV:   w = f_uw(U_NOP,       C_OP_LDV,   PC_LOAD_V);
            PC_DISP_NONE:  w = f_uw(U_NOP,       C_OP_NONE,  PC_EMIT);
            PC_DISP_QUIET: w = f_uw(U_NOP,       C_QUIET,    PC_EMIT);
            PC_DIV_START:  w = f_uw(U_DIV_START, C_NEVER,    PC_FETCH);
            PC_DIV_STEP:   w = f_uw(U_DIV_STEP,  C_DIV_BUSY, PC_DIV_STEP);
            PC_DIV_END:    w = f_uw(U_DIV_END,   C_DUR_NZ,   PC_H_PICK);
            PC_ADD_IMP:    w = f_uw(U_ADD_IMP,   C_ALWAYS,   PC_EMIT);
            PC_H_PICK:     w = f_uw(U_H_PICK,    C_NEVER,    PC_FETCH);
            PC_MUL_V:      w = f_uw(U_MUL_V,     C_NEVER,    PC_FETCH);
            PC_ADD_P:      w = f_uw(U_ADD_P,     C_NEVER,    PC_FETCH);
            PC_MUL_A:      w = f_uw(U_MUL_A,     C_NEVER,    PC_FETCH);
            PC_ADD_V:      w = f_uw(U_ADD_V,     C_LEFT_NZ,  PC_H_PICK);
            PC_ADV_DONE:   w = f_uw(U_NOP,       C_ALWAYS,   PC_EMIT);
            PC_LOAD_P:     w = f_uw(U_LOAD_P,    C_ALWAYS,   PC_EMIT);
            PC_LOAD_V:     w = f_uw(U_LOAD_V,    C_ALWAYS,   PC_EMIT);
            PC_EMIT:       w = f_uw(U_EMIT,      C_OUT_BUSY, PC_EMIT);
            PC_RETURN:     w = f_uw(U_NOP,       C_ALWAYS,   PC_FETCH);
            default:       w = f_uw(U_NOP,       C_ALWAYS,   PC_FETCH);
        endcase
        return w;
    endfunction

    // Magnitude of a two's complement word; the most negative value maps to 2^31.
    function automatic logic [DATA_W-1:0] f_mag(logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [ACC_W-1:0] f_sext(logic [DATA_W-1:0] v);
        return {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    // True when a wide sum fits the signed 32-bit range.
    function automatic logic f_fits(logic [ACC_W-1:0] v);
        return (v[ACC_W-1:DATA_W-1] == '0) || (v[ACC_W-1:DATA_W-1] == '1);
    endfunction

    function automatic logic [DATA_W-1:0] f_clamp(logic [ACC_W-1:0] v);
        if (f_fits(v)) begin
            return v[DATA_W-1:0];
        end
        return v[ACC_W-1] ? S32_MIN : S32_MAX;
    endfunction

endpackage

// File: rtl/euler_point_mass_integrator.sv
// -----------------------------------------------------------------------------
// euler_point_mass_integrator
// Forward Euler point mass in signed Q16.16, run by a microcoded sequencer.
// -----------------------------------------------------------------------------
// An input item is latched at the fetch word and dispatched on its opcode: a position or velocity
// load runs its load word, while the unused opcode and an empty advance go straight to emit. An
// impulse runs the 48-step bit-serial divider and one velocity add, an advance of nonzero length
// the divider and the five-word substep loop. Emit waits while an earlier result is stalled.
// One item at a time: a new input is taken only after the result reaches the output register.
// Synchronous active-low reset zeroes position and velocity, sets mass to 1.0.
`timescale 1ns / 1ps

module euler_point_mass_integrator
    import epmi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Item input channel.
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in               i_in_data,
    // Result output channel.
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out              o_out_data,
    // Mass register write channel.
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [MASS_W-1:0] i_cfg_data
);

    // Sequencer state.
    t_pc                  r_pc,       n_pc;
    // Architectural state and the mass register.
    logic [DATA_W-1:0]    r_pos,      n_pos;
    logic [DATA_W-1:0]    r_vel,      n_vel;
    logic [MASS_W-1:0]    r_mass,     n_mass;
    // Datapath working registers.
    t_in                  r_in,       n_in;
    logic                 r_sat,      n_sat;
    logic [DATA_W-1:0]    r_acc,      n_acc;
    logic [MASS_W-1:0]    r_div,      n_div;
    logic [DIV_W-1:0]     r_dq,       n_dq;
    logic [MASS_W-1:0]    r_rem,      n_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt,  n_div_cnt;
    logic                 r_neg,      n_neg;
    logic [DUR_W-1:0]     r_left,     n_left;
    logic [H_W-1:0]       r_h,        n_h;
    logic [PROD_W-1:0]    r_prod,     n_prod;
    logic                 r_prod_neg, n_prod_neg;
    // Output register.
    t_out                 r_out,      n_out;
    logic                 r_out_valid, n_out_valid;

    t_uword               uw;
    logic                 take;
    logic [DATA_W-1:0]    num_sel;
    logic [MASS_W:0]      trial;
    logic                 div_ge;
    logic [MASS_W:0]      div_diff;
    logic                 q_ovf;
    logic [DATA_W-1:0]    q_val;
    logic [DATA_W-1:0]    mul_src;
    logic [ACC_W-1:0]     term_mag;
    logic [ACC_W-1:0]     term;
    logic [ACC_W-1:0]     base;
    logic [ACC_W-1:0]     addend;
    logic [ACC_W-1:0]     sum;
    logic [H_W-1:0]       h_pick;

    // The current control word comes straight from the microcode store, so the
    // input side is open only while the program sits on its fetch word.
    assign uw          = f_urom(r_pc);
    assign o_in_stall  = (uw.op != U_LATCH);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Jump condition of the current word.
    always_comb begin
        case (uw.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_IN:    take = !i_in_valid;
            C_OP_LDP:   take = (r_in.opcode == OPC_LD_POS);
            C_OP_LDV:   take = (r_in.opcode == OPC_LD_VEL);
            C_OP_NONE:  take = (r_in.opcode != OPC_ADVANCE);
            C_QUIET:    take = (r_in.step_size == '0) && (r_in.impulse == '0);
            C_DIV_BUSY: take = (r_div_cnt != DIV_CNT_W'(1));
            C_DUR_NZ:   take = (r_in.step_size != '0);
            C_LEFT_NZ:  take = (r_left != '0);
            C_OUT_BUSY: take = r_out_valid && i_out_stall;
            default:    take = 1'b0;
        endcase
    end

    // Shared arithmetic. The divider works on the magnitude, one quotient bit
    // per cycle: the numerator shifts out of the top of r_dq while the
    // quotient shifts in at the bottom.
    always_comb begin
        num_sel  = (r_in.step_size == '0) ? r_in.impulse : r_in.force_req;
        trial    = {r_rem, r_dq[DIV_W-1]};
        div_ge   = (trial >= {1'b0, r_div});
        div_diff = trial - {1'b0, r_div};

        // A negative quotient may reach 2^31, a positive one only 2^31 - 1.
        q_ovf = r_neg ? (r_dq > DIV_W'(S32_MIN)) : (|r_dq[DIV_W-1:DATA_W-1]);
        q_val = r_neg ? (~r_dq[DATA_W-1:0] + 1'b1) : r_dq[DATA_W-1:0];

        mul_src  = (uw.op == U_MUL_A) ? r_acc : r_vel;
        term_mag = ACC_W'(r_prod[PROD_W-1:FRAC_W]);
        term     = r_prod_neg ? (~term_mag + 1'b1) : term_mag;
        base     = (uw.op == U_ADD_P) ? f_sext(r_pos) : f_sext(r_vel);
        addend   = (uw.op == U_ADD_IMP) ? f_sext(r_acc) : term;
        sum      = base + addend;

        h_pick = (r_left >= DUR_W'(SUBSTEP)) ? H_W'(SUBSTEP) : r_left[H_W-1:0];
    end

    // Next program address and the datapath action of the current word.
    always_comb begin
        n_pc        = take ? uw.tgt : (r_pc + 1'b1);
        n_pos       = r_pos;
        n_vel       = r_vel;
        n_mass      = r_mass;
        n_in        = r_in;
        n_sat       = r_sat;
        n_acc       = r_acc;
        n_div       = r_div;
        n_dq        = r_dq;
        n_rem       = r_rem;
        n_div_cnt   = r_div_cnt;
        n_neg       = r_neg;
        n_left      = r_left;
        n_h         = r_h;
        n_prod      = r_prod;
        n_prod_neg  = r_prod_neg;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_valid && o_cfg_ready) begin
            n_mass = i_cfg_data;
        end

        case (uw.op)
            U_LATCH: begin
                if (i_in_valid) begin
                    n_in  = i_in_data;
                    n_sat = 1'b0;
                end
            end
            U_DIV_START: begin
                // A mass of zero is treated as one LSB.
                n_neg     = num_sel[DATA_W-1];
                n_dq      = {f_mag(num_sel), {FRAC_W{1'b0}}};
                n_rem     = '0;
                n_div     = (r_mass == '0) ? MASS_W'(1) : r_mass;
                n_div_cnt = DIV_CNT_W'(DIV_W);
            end
            U_DIV_STEP: begin
                n_rem     = div_ge ? div_diff[MASS_W-1:0] : trial[MASS_W-1:0];
                n_dq      = {r_dq[DIV_W-2:0], div_ge};
                n_div_cnt = r_div_cnt - 1'b1;
            end
            U_DIV_END: begin
                n_acc  = q_ovf ? (r_neg ? S32_MIN : S32_MAX) : q_val;
                n_sat  = r_sat | q_ovf;
                n_left = r_in.step_size;
            end
            U_ADD_IMP, U_ADD_V: begin
                n_vel = f_clamp(sum);
                n_sat = r_sat | !f_fits(sum);
            end
            U_ADD_P: begin
                n_pos = f_clamp(sum);
                n_sat = r_sat | !f_fits(sum);
            end
            U_H_PICK: begin
                n_h    = h_pick;
                n_left = r_left - DUR_W'(h_pick);
            end
            U_MUL_V, U_MUL_A: begin
                n_prod     = PROD_W'(r_h) * PROD_W'(f_mag(mul_src));
                n_prod_neg = mul_src[DATA_W-1];
            end
            U_LOAD_P: begin
                n_pos = r_in.load_value;
            end
            U_LOAD_V: begin
                n_vel = r_in.load_value;
            end
            U_EMIT: begin
                if (!take) begin
                    n_out.position_out = r_pos;
                    n_out.velocity_out = r_vel;
                    n_out.saturated    = r_sat;
                    n_out_valid        = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_FETCH;
            r_pos       <= '0;
            r_vel       <= '0;
            r_mass      <= MASS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_pos       <= n_pos;
            r_vel       <= n_vel;
            r_mass      <= n_mass;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and working registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_in       <= n_in;
        r_sat      <= n_sat;
        r_acc      <= n_acc;
        r_div      <= n_div;
        r_dq       <= n_dq;
        r_rem      <= n_rem;
        r_div_cnt  <= n_div_cnt;
        r_neg      <= n_neg;
        r_left     <= n_left;
        r_h        <= n_h;
        r_prod     <= n_prod;
        r_prod_neg <= n_prod_neg;
        r_out      <= n_out;
    end

    `include "euler_point_mass_integrator_assert.svh"

    // A transfer on the input side always hands control to the dispatcher.
    `EPMI_ASSERT_NEXT(a_fetch_to_dispatch, i_in_valid && !o_in_stall, r_pc == PC_DISP_LDP, "input transfer did not start dispatch")
    // The divider never runs past its last quotient bit.
    `EPMI_ASSERT_NOW(a_div_count_live, r_pc == PC_DIV_STEP, r_div_cnt != '0, "divider stepped with an empty count")
    // Every substep that reaches the multiplier has a nonzero length.
    `EPMI_ASSERT_NOW(a_substep_nonzero, r_pc == PC_MUL_V, r_h != '0, "zero-length substep")

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Testbench for euler_point_mass_integrator
// Sends load, impulse and advance items through the item channel and predicts
// the position and velocity after each one in fixed point. Every result is
// compared with the prediction field by field, in order. The mass register is
// reprogrammed between phases, and both channels idle and stall at random.
// -----------------------------------------------------------------------------

module tb;
    import epmi_pkg::*;

    // Opcode 3 is left unused by the block and must change nothing.
    localparam logic [OPC_W-1:0] OPC_UNUSED = 2'd3;

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;
    localparam logic [DATA_W-1:0] ONE_Q16 = 32'h0001_0000;
    localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};
    localparam logic [MASS_W-1:0] MASS_MAX = {MASS_W{1'b1}};

    // Time limit for the whole run in nanoseconds, after which the bench reports a failure.
    localparam longint RUN_LIMIT_NS = 64'd200_000_000;
    localparam int TAIL_CYCLES = 20;
    localparam int MAX_REPORTS = 10;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [MASS_W-1:0] i_cfg_data = '0;

    // Predicted state of the point mass and the programmed mass.
    logic signed [DATA_W-1:0] pos_q;
    logic signed [DATA_W-1:0] vel_q;
    logic [MASS_W-1:0] mass_q;

    t_out expected_states[$];

    bit calm = 1'b0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned saturating_results = 0;
    int unsigned mass_writes = 0;
    int unsigned mismatches = 0;

    euler_point_mass_integrator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Fixed-point predictor
    // ---------------------------------------------------------------------

    function automatic longint clamp_word(longint v, inout bit sat);
        if (v > WORD_MAX) begin
            sat = 1'b1;
            return WORD_MAX;
        end
        if (v < WORD_MIN) begin
            sat = 1'b1;
            return WORD_MIN;
        end
        return v;
    endfunction

    // (num << 16) / mass on magnitudes, so the quotient truncates toward zero.
    // A mass of zero behaves as the smallest non-zero mass.
    function automatic longint div_by_mass(longint num, inout bit sat);
        longint unsigned divisor;
        longint unsigned mag;
        longint unsigned quot;
        divisor = (mass_q == '0) ? 64'd1 : longint'(mass_q);
        mag = (num < 0) ? longint'(-num) : num;
        quot = (mag << FRAC_W) / divisor;
        if (num < 0) begin
            if (quot > 64'h8000_0000) begin
                sat = 1'b1;
                return WORD_MIN;
            end
            return -longint'(quot);
        end
        if (quot > 64'h7FFF_FFFF) begin
            sat = 1'b1;
            return WORD_MAX;
        end
        return longint'(quot);
    endfunction

    // (h * v) >> 16 on the magnitude, again truncating toward zero.
    function automatic longint scale_by_h(longint unsigned h, longint v);
        longint unsigned mag;
        longint unsigned prod;
        mag = (v < 0) ? longint'(-v) : v;
        prod = (h * mag) >> FRAC_W;
        return (v < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    // Applies one accepted item to the predicted state and returns the result
    // that the block must produce for it.
    function automatic t_out integrate_item(t_in it);
        bit sat;
        longint pos;
        longint vel;
        longint acc;
        longint unsigned left;
        longint unsigned h;
        t_out res;
        sat = 1'b0;
        pos = pos_q;
        vel = vel_q;
        case (it.opcode)
            OPC_LD_POS: begin
                pos = $signed(it.load_value);
            end
            OPC_LD_VEL: begin
                vel = $signed(it.load_value);
            end
            OPC_ADVANCE: begin
                if (it.step_size == '0) begin
                    if (it.impulse != '0) begin
                        acc = div_by_mass($signed(it.impulse), sat);
                        vel = clamp_word(vel + acc, sat);
                    end
                end else begin
                    // At least one substep runs, so a clamped quotient counts.
                    acc = div_by_mass($signed(it.force_req), sat);
                    left = it.step_size;
                    while (left > 0) begin
                        h = (left >= SUBSTEP) ? longint'(SUBSTEP) : left;
                        left -= h;
                        pos = clamp_word(pos + scale_by_h(h, vel), sat);
                        vel = clamp_word(vel + scale_by_h(h, acc), sat);
                    end
                end
            end
            default: begin
            end
        endcase
        pos_q = pos[DATA_W-1:0];
        vel_q = vel[DATA_W-1:0];
        res.position_out = pos_q;
        res.velocity_out = vel_q;
        res.saturated = sat;
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Channel drivers
    // ---------------------------------------------------------------------

    // One item transfer, preceded by a random gap unless the phase is calm.
    // The prediction is made at the edge where the transfer takes place.
    task automatic send_item(input t_in it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        expected_states.push_back(integrate_item(it));
        items_sent++;
    endtask

    // Drops the item valid and waits until every predicted result has come.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (expected_states.size() != 0) @(posedge i_clk);
    endtask

    // Register write; only called while the block is idle.
    task automatic write_mass(input logic [MASS_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        mass_q = value;
        mass_writes++;
    endtask

    function automatic t_in mk_item(logic [OPC_W-1:0] opc, logic [DUR_W-1:0] dur,
                                    logic [DATA_W-1:0] frc, logic [DATA_W-1:0] imp,
                                    logic [DATA_W-1:0] ldv);
        t_in it;
        it.opcode = opc;
        it.step_size = dur;
        it.force_req = frc;
        it.impulse = imp;
        it.load_value = ldv;
        return it;
    endfunction

    // Word with a bias towards the extremes and small magnitudes.
    function automatic logic [DATA_W-1:0] pick_word();
        int small_val;
        case ($urandom_range(0, 9))
            0: return S32_MAX;
            1: return S32_MIN;
            2: return '0;
            3: return $urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF;
            4, 5: begin
                small_val = int'($urandom_range(0, 1 << 18)) - (1 << 17);
                return small_val;
            end
            default: return $urandom();
        endcase
    endfunction

    // Output stall: for each result, hold stall high for a random number of
    // cycles, then low until the result transfer happens.
    initial begin : drive_out_stall
        int hold;
        forever begin
            hold = calm ? 0 : $urandom_range(0, 5);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    // Result checker: every result transfer is compared with the oldest
    // prediction.
    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (o_out_data.saturated) begin
                saturating_results++;
            end
            if (expected_states.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected result %0d: pos %h vel %h sat %b", results_seen,
                             o_out_data.position_out, o_out_data.velocity_out,
                             o_out_data.saturated);
                end
            end else begin
                want = expected_states.pop_front();
                if (o_out_data.position_out !== want.position_out ||
                    o_out_data.velocity_out !== want.velocity_out ||
                    o_out_data.saturated !== want.saturated) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("result %0d mismatch: expected pos %h vel %h sat %b, got pos %h vel %h sat %b",
                                 results_seen, want.position_out, want.velocity_out,
                                 want.saturated, o_out_data.position_out,
                                 o_out_data.velocity_out, o_out_data.saturated);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Loads at both extremes, the unused opcode and an empty advance.
    task automatic test_loads_and_unused();
        send_item(mk_item(OPC_LD_POS, DUR_W'($urandom()), $urandom(), $urandom(), S32_MAX));
        send_item(mk_item(OPC_LD_VEL, DUR_W'($urandom()), $urandom(), $urandom(), S32_MIN));
        send_item(mk_item(OPC_UNUSED, DUR_W'($urandom()), $urandom(), $urandom(), $urandom()));
        send_item(mk_item(OPC_ADVANCE, '0, $urandom(), '0, $urandom()));
        send_item(mk_item(OPC_LD_POS, DUR_W'($urandom()), $urandom(), $urandom(), S32_MIN));
        send_item(mk_item(OPC_LD_VEL, DUR_W'($urandom()), $urandom(), $urandom(), S32_MAX));
        wait_for_results();
    endtask

    // Impulses at the reset mass, driving the velocity into its upper limit and back below zero.
    task automatic test_impulses();
        send_item(mk_item(OPC_LD_VEL, '0, '0, '0, '0));
        send_item(mk_item(OPC_ADVANCE, '0, $urandom(), S32_MAX, $urandom()));
        send_item(mk_item(OPC_ADVANCE, '0, $urandom(), S32_MAX, $urandom()));
        send_item(mk_item(OPC_ADVANCE, '0, $urandom(), S32_MIN, $urandom()));
        send_item(mk_item(OPC_ADVANCE, '0, $urandom(), 32'hFFFF_FFFF, $urandom()));
        wait_for_results();
    endtask

    // Durations around the substep boundary, and the longest duration.
    task automatic test_advance_lengths();
        send_item(mk_item(OPC_LD_POS, '0, '0, '0, '0));
        send_item(mk_item(OPC_LD_VEL, '0, '0, '0, ONE_Q16));
        send_item(mk_item(OPC_ADVANCE, 24'd1, '0, '0, '0));
        send_item(mk_item(OPC_ADVANCE, DUR_W'(SUBSTEP - 1), ONE_Q16, '0, '0));
        send_item(mk_item(OPC_ADVANCE, DUR_W'(SUBSTEP), S32_MAX, '0, '0));
        send_item(mk_item(OPC_ADVANCE, DUR_W'(SUBSTEP + 1), S32_MIN, '0, '0));
        send_item(mk_item(OPC_ADVANCE, DUR_W'(2 * SUBSTEP), S32_MAX, '0, '0));
        send_item(mk_item(OPC_ADVANCE, DUR_MAX, S32_MIN, S32_MAX, '0));
        wait_for_results();
    endtask

    // Zero mass, the smallest and the largest mass.
    task automatic test_mass_extremes();
        write_mass('0);
        send_item(mk_item(OPC_ADVANCE, '0, '0, 32'd1, '0));
        send_item(mk_item(OPC_ADVANCE, DUR_W'(SUBSTEP), 32'd1, '0, '0));
        wait_for_results();
        write_mass(MASS_W'(1));
        send_item(mk_item(OPC_ADVANCE, '0, '0, 32'hFFFF_FFFF, '0));
        send_item(mk_item(OPC_ADVANCE, DUR_W'(SUBSTEP), 32'h0000_8000, '0, '0));
        wait_for_results();
        write_mass(MASS_MAX);
        send_item(mk_item(OPC_ADVANCE, '0, '0, S32_MAX, '0));
        send_item(mk_item(OPC_ADVANCE, DUR_W'(3 * SUBSTEP), S32_MIN, '0, '0));
        wait_for_results();
    endtask

    // Random traffic in phases, each with its own mass. Most items are
    // advances of a few substeps; a few are long.
    task automatic test_random_traffic();
        logic [MASS_W-1:0] masses[6];
        t_in it;
        int sel;
        int r;
        masses[0] = MASS_RESET;
        masses[1] = MASS_W'(1);
        masses[2] = MASS_MAX;
        masses[3] = MASS_W'($urandom_range(1, 4096));
        masses[4] = MASS_W'($urandom());
        masses[5] = MASS_W'($urandom_range(32768, 262144));
        for (int ph = 0; ph < 6; ph++) begin
            calm = (ph == 3);
            write_mass(masses[ph]);
            for (int n = 0; n < 200; n++) begin
                sel = $urandom_range(0, 99);
                if (sel < 60) begin
                    it.opcode = OPC_ADVANCE;
                end else if (sel < 78) begin
                    it.opcode = OPC_LD_POS;
                end else if (sel < 96) begin
                    it.opcode = OPC_LD_VEL;
                end else begin
                    it.opcode = OPC_UNUSED;
                end
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    it.step_size = '0;
                end else if (r < 65) begin
                    it.step_size = DUR_W'($urandom_range(1, 10 * SUBSTEP));
                end else if (r < 90) begin
                    it.step_size = DUR_W'($urandom_range(1, 65535));
                end else if (r < 98) begin
                    it.step_size = DUR_W'(SUBSTEP * $urandom_range(1, 12)
                                          + $urandom_range(0, 2) - 1);
                end else begin
                    it.step_size = DUR_W'($urandom_range(65536, 1 << 20));
                end
                it.force_req = pick_word();
                it.impulse = pick_word();
                it.load_value = pick_word();
                send_item(it);
            end
            wait_for_results();
        end
        calm = 1'b0;
    endtask

    initial begin
        pos_q = '0;
        vel_q = '0;
        mass_q = MASS_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_loads_and_unused();
        test_impulses();
        test_advance_lengths();
        test_mass_extremes();
        test_random_traffic();

        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d items through %0d mass writes; %0d results checked, %0d saturating.",
                 items_sent, mass_writes, results_seen, saturating_results);
        $display("Mismatched or unexpected results: %0d; predictions left over: %0d.",
                 mismatches, expected_states.size());
        if (mismatches == 0 && expected_states.size() == 0) begin
            $display("** euler_point_mass_integrator: PASSED **");
        end else begin
            $display("** euler_point_mass_integrator: FAILED **");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Run limit reached with %0d predictions outstanding.", expected_states.size());
        $display("** euler_point_mass_integrator: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/epmi_pkg.sv
rtl/euler_point_mass_integrator.sv
sim/tb.sv
